/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the alignment error profile counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked property check with reset disable and a fixed message.
`define AEPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
// Clocked property check with reset disable and a caller message.
`define AEPC_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define AEPC_ASSERT(lbl, clk, rst_n, prop)
`define AEPC_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif
`endif

/* hw/rtl/aepc_pkg.sv */
// Shared constants, codes, types and helpers of the alignment error profile counter.
package aepc_pkg;

	localparam int NUM_COLUMNS_DEF = 64;
	localparam int QUAL_CODES_DEF  = 128;
	localparam int COUNT_BITS_DEF  = 32;

	localparam int QUAL_BASE      = 33;
	localparam int QUAL_END       = 128;
	localparam int INDEL_GROUP    = 14;
	localparam int PLAIN_GROUP    = 4;
	localparam int INS_BEFORE_OFS = 8;
	localparam int DEL_OFS        = 12;
	localparam int MAX_ROWS       = 4 * INDEL_GROUP;
	localparam int ROW_W          = 6;
	localparam int COL_W          = 6;

	// func codes
	localparam logic [2:0] FN_START = 3'd0;
	localparam logic [2:0] FN_PAIR  = 3'd1;
	localparam logic [2:0] FN_INS   = 3'd2;
	localparam logic [2:0] FN_DEL   = 3'd3;
	localparam logic [2:0] FN_MAP   = 3'd4;
	localparam logic [2:0] FN_READ  = 3'd5;
	localparam logic [2:0] FN_CLEAR = 3'd6;

	// status codes
	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_BAD_TRUE = 3'd1;
	localparam logic [2:0] STS_BAD_OBS  = 3'd2;
	localparam logic [2:0] STS_BAD_QUAL = 3'd3;
	localparam logic [2:0] STS_RANGE    = 3'd4;

	// base codes
	localparam logic [2:0] BASE_T = 3'd3;
	localparam logic [2:0] BASE_N = 3'd4;
	localparam logic [2:0] TB_END = 3'd5;

	// config register indexes
	localparam logic CFG_COUNT_INDELS = 1'b0;

	typedef struct packed {
		logic accept;
		logic eval;
		logic rd_a;
		logic wr_a;
		logic rd_b;
		logic wr_b;
		logic rd_tbl;
		logic clr_wr;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic use_a;
		logic use_b;
		logic rd_tbl;
		logic clr;
		logic use_b_pend;
		logic sweep_last;
		logic out_free;
	} dp_stat_t;

	// Row of a transition: base group plus offset inside the group.
	function automatic logic [ROW_W-1:0] row_of(input logic [1:0] base, input logic indels,
			input logic [3:0] ofs);
		logic [ROW_W-1:0] grp;
		grp = indels ? ROW_W'(INDEL_GROUP) : ROW_W'(PLAIN_GROUP);
		return ROW_W'(base) * grp + ROW_W'(ofs);
	endfunction

endpackage

/* hw/rtl/aepc_ctrl.sv */
// Sequencing state machine of the alignment error profile counter.
`include "assert_macros.svh"
module aepc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  aepc_pkg::dp_stat_t   stat,
	output aepc_pkg::ctrl_cmd_t  cmd
);
	import aepc_pkg::*;

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_EVAL   = 9'b000000100,
		S_RD_A   = 9'b000001000,
		S_WR_A   = 9'b000010000,
		S_RD_B   = 9'b000100000,
		S_WR_B   = 9'b001000000,
		S_RD_TBL = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   clr_item_q, clr_item_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d      = state_q;
		clr_item_d   = clr_item_q;
		cmd          = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.sweep_last) begin
					state_d = clr_item_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				priority if (stat.use_a) begin
					state_d = S_RD_A;
				end else if (stat.use_b) begin
					state_d = S_RD_B;
				end else if (stat.rd_tbl) begin
					state_d = S_RD_TBL;
				end else if (stat.clr) begin
					state_d    = S_CLEAR;
					clr_item_d = 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RD_A: begin
				cmd.rd_a = 1'b1;
				state_d  = S_WR_A;
			end
			S_WR_A: begin
				cmd.wr_a = 1'b1;
				state_d  = stat.use_b_pend ? S_RD_B : S_DONE;
			end
			S_RD_B: begin
				cmd.rd_b = 1'b1;
				state_d  = S_WR_B;
			end
			S_WR_B: begin
				cmd.wr_b = 1'b1;
				state_d  = S_DONE;
			end
			S_RD_TBL: begin
				cmd.rd_tbl = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					clr_item_d   = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_item_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_item_q <= clr_item_d;
		end
	end

	`AEPC_ASSERT_MSG(a_accept_to_eval, clk, arst_n, (s_tvalid && s_tready) |=> (state_q == S_EVAL), "accepted item not evaluated")
	`AEPC_ASSERT_MSG(a_wr_a_after_rd, clk, arst_n, (state_q == S_WR_A) |-> ($past(state_q) == S_RD_A), "count write A without read")
	`AEPC_ASSERT_MSG(a_wr_b_after_rd, clk, arst_n, (state_q == S_WR_B) |-> ($past(state_q) == S_RD_B), "count write B without read")
	`AEPC_ASSERT(a_load_when_free, clk, arst_n, cmd.load_out |-> stat.out_free)
	`AEPC_ASSERT(a_sweep_ends, clk, arst_n, (state_q == S_CLEAR && stat.sweep_last) |=> (state_q != S_CLEAR))

endmodule

/* hw/rtl/aepc_datapath.sv */
// Item registers, quality map, counts memory, history state and output register.
module aepc_datapath #(
	parameter int NUM_COLUMNS = aepc_pkg::NUM_COLUMNS_DEF,
	parameter int QUAL_CODES  = aepc_pkg::QUAL_CODES_DEF,
	parameter int COUNT_BITS  = aepc_pkg::COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 count_indels,
	input  logic [39:0]          s_tdata,   // ref_base, read_base, qual, table_row, table_col, map_column
	input  logic [2:0]           s_tuser,   // func
	input  aepc_pkg::ctrl_cmd_t  cmd,
	output aepc_pkg::dp_stat_t   stat,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata    // count, status
);
	import aepc_pkg::*;

	localparam int DEPTH = MAX_ROWS * NUM_COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int QW    = $clog2(QUAL_CODES);

	// accepted item
	logic [2:0]       func_q, tb_q, ob_q;
	logic [7:0]       q_q;
	logic [ROW_W-1:0] trow_q;
	logic [COL_W-1:0] tcol_q;
	logic [6:0]       mc_q;

	// quality map
	logic [COL_W-1:0]      map_mem [QUAL_CODES];
	logic [QUAL_CODES-1:0] mapped_q;
	logic [COL_W-1:0]      map_col_q;
	logic                  map_ok_q;

	// history
	logic [1:0]       ltb_q;
	logic             ltv_q;
	logic [COL_W-1:0] lq_q;
	logic             lqv_q;
	logic [2:0]       lqs_q;

	// counts
	logic [COUNT_BITS-1:0] cnt_mem [DEPTH];
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [AW-1:0]         addr_a_q, addr_b_q, tbl_addr_q, clr_cnt_q;
	logic                  use_b_q, rd_tbl_q;
	logic [2:0]            res_st_q;

	// output register
	logic        out_valid_q;
	logic [31:0] count_q;
	logic [2:0]  status_q;

	// evaluation
	logic             range_bad;
	logic [2:0]       lk_st;
	logic [COL_W-1:0] lk_col;
	logic [2:0]       ev_st;
	logic             ev_use_a, ev_use_b, ev_rd_tbl, ev_clr, ev_map_wr;
	logic [ROW_W-1:0] ev_row_a, ev_row_b;
	logic [COL_W-1:0] ev_col_a, ev_col_b;
	logic [1:0]       nx_ltb;
	logic             nx_ltv, nx_lqv;
	logic [COL_W-1:0] nx_lq;
	logic [2:0]       nx_lqs;
	logic [1:0]       tb2, ob2;

	assign tb2 = tb_q[1:0];
	assign ob2 = ob_q[1:0];

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q    <= s_tuser;
			tb_q      <= s_tdata[2:0];
			ob_q      <= s_tdata[5:3];
			q_q       <= s_tdata[13:6];
			trow_q    <= s_tdata[19:14];
			tcol_q    <= s_tdata[25:20];
			mc_q      <= s_tdata[32:26];
			map_col_q <= map_mem[s_tdata[6 +: QW]];
			map_ok_q  <= mapped_q[s_tdata[6 +: QW]];
		end
		if (cmd.eval && ev_map_wr) begin
			map_mem[q_q[QW-1:0]] <= mc_q[COL_W-1:0];
		end
	end

	// quality lookup
	always_comb begin
		range_bad = (q_q < 8'(QUAL_BASE)) || ({1'b0, q_q} >= 9'(QUAL_CODES));
		if (range_bad || !map_ok_q) begin
			lk_st = STS_BAD_QUAL;
		end else if ({2'b0, map_col_q} >= 8'(NUM_COLUMNS)) begin
			lk_st = STS_RANGE;
		end else begin
			lk_st = STS_OK;
		end
		lk_col = (lk_st == STS_OK) ? map_col_q : '0;
	end

	always_comb begin
		ev_st     = STS_OK;
		ev_use_a  = 1'b0;
		ev_use_b  = 1'b0;
		ev_row_a  = '0;
		ev_row_b  = '0;
		ev_col_a  = '0;
		ev_col_b  = '0;
		ev_rd_tbl = 1'b0;
		ev_clr    = 1'b0;
		ev_map_wr = 1'b0;
		nx_ltb    = ltb_q;
		nx_ltv    = ltv_q;
		nx_lq     = lq_q;
		nx_lqv    = lqv_q;
		nx_lqs    = lqs_q;
		unique case (func_q)
			FN_START: begin
				nx_ltv = 1'b0;
				nx_lqv = 1'b0;
				nx_lqs = STS_OK;
			end
			FN_PAIR: begin
				if (tb_q > BASE_T) begin
					ev_st = STS_BAD_TRUE;
				end else if (ob_q > BASE_N) begin
					ev_st = STS_BAD_OBS;
				end else if (ob_q != BASE_N) begin
					if (lk_st != STS_OK) begin
						ev_st = lk_st;
					end else begin
						ev_use_a = 1'b1;
						ev_row_a = row_of(tb2, count_indels, {2'b0, ob2});
						ev_col_a = lk_col;
						nx_ltb   = tb2;
						nx_ltv   = 1'b1;
						nx_lq    = lk_col;
						nx_lqv   = 1'b1;
						nx_lqs   = STS_OK;
					end
				end
			end
			FN_INS: begin
				if (count_indels) begin
					if (range_bad) begin
						ev_st = STS_BAD_QUAL;
					end else begin
						// count after the previous true base
						if (ltv_q) begin
							if (ob_q < BASE_N) begin
								ev_use_a = 1'b1;
								ev_row_a = row_of(ltb_q, 1'b1, 4'(PLAIN_GROUP) + {2'b0, ob2});
								ev_col_a = lk_col;
								if (lk_st != STS_OK) ev_st = lk_st;
							end else if (ob_q != BASE_N) begin
								ev_st = STS_BAD_OBS;
							end
						end
						// count before the next true base
						if (ev_st == STS_OK && tb_q != TB_END) begin
							if (tb_q > BASE_T) begin
								ev_st = STS_BAD_TRUE;
							end else if (ob_q < BASE_N) begin
								ev_use_b = 1'b1;
								ev_row_b = row_of(tb2, 1'b1, 4'(INS_BEFORE_OFS) + {2'b0, ob2});
								ev_col_b = lk_col;
								if (lk_st != STS_OK) ev_st = lk_st;
							end else if (ob_q != BASE_N) begin
								ev_st = STS_BAD_OBS;
							end
						end
					end
				end
				if (ev_st == STS_OK) begin
					nx_lq  = lk_col;
					nx_lqv = 1'b1;
					nx_lqs = lk_st;
				end
			end
			FN_DEL: begin
				if (count_indels) begin
					if (tb_q > BASE_T) begin
						ev_st = STS_BAD_TRUE;
					end else if (lqv_q && lqs_q != STS_OK) begin
						ev_st = lqs_q;
					end else if (q_q != 8'(QUAL_END) && lk_st != STS_OK) begin
						ev_st = lk_st;
					end else begin
						ev_use_a = lqv_q;
						ev_row_a = row_of(tb2, 1'b1, 4'(DEL_OFS));
						ev_col_a = lq_q;
						ev_use_b = (q_q != 8'(QUAL_END));
						ev_row_b = row_of(tb2, 1'b1, 4'(DEL_OFS + 1));
						ev_col_b = lk_col;
					end
				end
				if (ev_st == STS_OK) begin
					if (tb_q <= BASE_T) begin
						nx_ltb = tb2;
						nx_ltv = 1'b1;
					end else begin
						nx_ltv = 1'b0;
					end
				end
			end
			FN_MAP: begin
				if ({1'b0, q_q} >= 9'(QUAL_CODES)) begin
					ev_st = STS_RANGE;
				end else begin
					ev_map_wr = 1'b1;
				end
			end
			FN_READ: begin
				if (trow_q >= (count_indels ? ROW_W'(MAX_ROWS) : ROW_W'(4 * PLAIN_GROUP)) ||
						{2'b0, tcol_q} >= 8'(NUM_COLUMNS)) begin
					ev_st = STS_RANGE;
				end else begin
					ev_rd_tbl = 1'b1;
				end
			end
			FN_CLEAR: begin
				ev_clr = 1'b1;
			end
			default: begin
			end
		endcase
		// a failing item leaves the table alone
		if (ev_st != STS_OK) begin
			ev_use_a = 1'b0;
			ev_use_b = 1'b0;
		end
	end

	// decision registers and history
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			addr_a_q   <= AW'(ev_row_a) * AW'(NUM_COLUMNS) + AW'(ev_col_a);
			addr_b_q   <= AW'(ev_row_b) * AW'(NUM_COLUMNS) + AW'(ev_col_b);
			tbl_addr_q <= AW'(trow_q) * AW'(NUM_COLUMNS) + AW'(tcol_q);
			res_st_q   <= ev_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ltb_q    <= '0;
			ltv_q    <= 1'b0;
			lq_q     <= '0;
			lqv_q    <= 1'b0;
			lqs_q    <= STS_OK;
			mapped_q <= '0;
			use_b_q  <= 1'b0;
			rd_tbl_q <= 1'b0;
		end else if (cmd.eval) begin
			ltb_q    <= nx_ltb;
			ltv_q    <= nx_ltv;
			lq_q     <= nx_lq;
			lqv_q    <= nx_lqv;
			lqs_q    <= nx_lqs;
			use_b_q  <= ev_use_b;
			rd_tbl_q <= ev_rd_tbl;
			if (ev_map_wr) mapped_q[q_q[QW-1:0]] <= ~mc_q[6];
		end
	end

	// counts memory: one read and one write port, registered read
	always_ff @(posedge clk) begin
		if (cmd.rd_a) begin
			cnt_rd_q <= cnt_mem[addr_a_q];
		end else if (cmd.rd_b) begin
			cnt_rd_q <= cnt_mem[addr_b_q];
		end else if (cmd.rd_tbl) begin
			cnt_rd_q <= cnt_mem[tbl_addr_q];
		end
		if (cmd.clr_wr) begin
			cnt_mem[clr_cnt_q] <= '0;
		end else if (cmd.wr_a) begin
			cnt_mem[addr_a_q] <= (&cnt_rd_q) ? cnt_rd_q : cnt_rd_q + COUNT_BITS'(1);
		end else if (cmd.wr_b) begin
			cnt_mem[addr_b_q] <= (&cnt_rd_q) ? cnt_rd_q : cnt_rd_q + COUNT_BITS'(1);
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= stat.sweep_last ? '0 : clr_cnt_q + AW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			count_q  <= rd_tbl_q ? 32'(cnt_rd_q) : '0;
			status_q <= res_st_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, status_q, count_q};

	assign stat.use_a      = ev_use_a;
	assign stat.use_b      = ev_use_b;
	assign stat.rd_tbl     = ev_rd_tbl;
	assign stat.clr        = ev_clr;
	assign stat.use_b_pend = use_b_q;
	assign stat.sweep_last = (clr_cnt_q == AW'(DEPTH - 1));
	assign stat.out_free   = !out_valid_q || m_tready;

endmodule

/* hw/rtl/alignment_error_profile_counter_top.sv */
// Top level of the alignment error profile counter: config register and block wiring.
//
// Input items arrive on s_tvalid/s_tready with the command code on s_tuser and the
// operands on s_tdata; one result item per input leaves on m_tvalid/m_tready.
// An item is evaluated one at a time: accept, an evaluate step against the
// quality map and the base/quality history, then the counts memory work, then the
// result is loaded into the output register.
// Items that touch no count go from evaluation straight to the result load; a count
// read-out reads one cell first, and a counting item works one cell or two
// (insertions and deletions); each counted cell is a read then a saturating write on
// the single port pair of the counts memory. A clear item sweeps all 56*NUM_COLUMNS
// cells of the memory (3584 at the default), one cell a cycle, before its result.
// After reset the same clearing pass runs and s_tready stays low for its length;
// the APB register stays writable throughout. count_indels resets to 0.
// The output register holds a finished result while m_tready is low; the next item
// is taken and worked on meanwhile, and only its result load waits for the slot.
module alignment_error_profile_counter_top #(
	parameter int NUM_COLUMNS = aepc_pkg::NUM_COLUMNS_DEF,
	parameter int QUAL_CODES  = aepc_pkg::QUAL_CODES_DEF,
	parameter int COUNT_BITS  = aepc_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// ref_base[2:0], read_base[5:3], qual[13:6], table_row[19:14], table_col[25:20],
	// map_column[32:26], zero pad[39:33]
	input  logic [39:0] s_tdata,
	input  logic [2:0]  s_tuser,   // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // count[31:0], status[34:32], zero pad[39:35]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import aepc_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      count_indels_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_indels_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == CFG_COUNT_INDELS) begin
			count_indels_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == CFG_COUNT_INDELS) ? {31'b0, count_indels_q} : '0;

	aepc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	aepc_datapath #(
		.NUM_COLUMNS (NUM_COLUMNS),
		.QUAL_CODES  (QUAL_CODES),
		.COUNT_BITS  (COUNT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.count_indels (count_indels_q),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.cmd          (cmd),
		.stat         (stat),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata)
	);

endmodule
